// ===== sv/sorted_table_binary_search_macros.svh =====
// Assertion macros used by the top-level RTL.
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define BSRCH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BSRCH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BSRCH_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define BSRCH_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== sv/bsrch_pkg.sv =====
`timescale 1ns / 1ps

package bsrch_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int INDEX_WIDTH = $clog2(TABLE_DEPTH);
   localparam int ENTRY_WIDTH = 32;
   localparam int LOW_WIDTH   = 9;   // bound up to TABLE_DEPTH
   localparam int HIGH_WIDTH  = 10;  // signed, down to -1

   // request tdata layout, lowest bit up
   localparam int REQ_TDATA_WIDTH = 96;
   localparam int ENTRY_INDEX_LSB = 0;
   localparam int ENTRY_VALUE_LSB = 8;
   localparam int SEARCH_LOW_LSB  = 40;
   localparam int SEARCH_HIGH_LSB = 48;
   localparam int SEARCH_KEY_LSB  = 57;
   localparam int SEARCH_LOW_WIDTH  = 8;
   localparam int SEARCH_HIGH_WIDTH = 9;

   localparam int RSP_TDATA_WIDTH = 8;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PROBE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic write_en;
      logic load_req;
      logic probe;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic nonempty;
      logic hit;
      logic out_free;
   } status_type;

endpackage

// ===== sv/bsrch_ram.sv =====
`timescale 1ns / 1ps

module bsrch_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bsrch_ctrl.sv =====
`timescale 1ns / 1ps

module bsrch_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_opcode,
   output logic                   req_tready,
   input  bsrch_pkg::status_type  status,
   output bsrch_pkg::cmd_type     cmd
);

   bsrch_pkg::state_type state_ff;
   bsrch_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsrch_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsrch_pkg::ST_IDLE: begin
            if (req_tvalid && req_opcode == bsrch_pkg::OP_SEARCH) begin
               state_in = bsrch_pkg::ST_CHECK;
            end
         end
         bsrch_pkg::ST_CHECK: begin
            state_in = status.nonempty ? bsrch_pkg::ST_PROBE : bsrch_pkg::ST_DONE;
         end
         bsrch_pkg::ST_PROBE: begin
            state_in = status.hit ? bsrch_pkg::ST_DONE : bsrch_pkg::ST_CHECK;
         end
         bsrch_pkg::ST_DONE: begin
            if (status.out_free) begin
               state_in = bsrch_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bsrch_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         bsrch_pkg::ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.write_en = req_tvalid && req_opcode == bsrch_pkg::OP_WRITE;
            cmd.load_req = req_tvalid && req_opcode == bsrch_pkg::OP_SEARCH;
         end
         bsrch_pkg::ST_PROBE: begin
            cmd.probe = 1'b1;
         end
         bsrch_pkg::ST_DONE: begin
            cmd.load_rsp = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== sv/bsrch_dp.sv =====
`timescale 1ns / 1ps

module bsrch_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [bsrch_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   input  bsrch_pkg::cmd_type                   cmd,
   output bsrch_pkg::status_type                status,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bsrch_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   output logic                                 rsp_tuser
);

   logic [bsrch_pkg::INDEX_WIDTH-1:0]       entry_index;
   logic signed [bsrch_pkg::ENTRY_WIDTH-1:0] entry_value;
   logic [bsrch_pkg::SEARCH_LOW_WIDTH-1:0]  search_low;
   logic signed [bsrch_pkg::SEARCH_HIGH_WIDTH-1:0] search_high;
   logic signed [bsrch_pkg::ENTRY_WIDTH-1:0] search_key;

   assign entry_index = req_tdata[bsrch_pkg::ENTRY_INDEX_LSB +: bsrch_pkg::INDEX_WIDTH];
   assign entry_value = req_tdata[bsrch_pkg::ENTRY_VALUE_LSB +: bsrch_pkg::ENTRY_WIDTH];
   assign search_low  = req_tdata[bsrch_pkg::SEARCH_LOW_LSB +: bsrch_pkg::SEARCH_LOW_WIDTH];
   assign search_high = req_tdata[bsrch_pkg::SEARCH_HIGH_LSB +: bsrch_pkg::SEARCH_HIGH_WIDTH];
   assign search_key  = req_tdata[bsrch_pkg::SEARCH_KEY_LSB +: bsrch_pkg::ENTRY_WIDTH];

   logic [bsrch_pkg::LOW_WIDTH-1:0]          low_ff, low_in;
   logic signed [bsrch_pkg::HIGH_WIDTH-1:0]  high_ff, high_in;
   logic signed [bsrch_pkg::ENTRY_WIDTH-1:0] key_ff, key_in;
   logic                                     found_ff, found_in;
   logic [bsrch_pkg::INDEX_WIDTH-1:0]        match_ff, match_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic                                     rsp_found_ff, rsp_found_in;
   logic [bsrch_pkg::INDEX_WIDTH-1:0]        rsp_index_ff, rsp_index_in;

   logic [bsrch_pkg::HIGH_WIDTH-1:0]         mid_sum;
   logic [bsrch_pkg::INDEX_WIDTH-1:0]        mid;
   logic signed [bsrch_pkg::ENTRY_WIDTH-1:0] rd_data;
   logic                                     nonempty;

   // with a non-empty range both bounds are in 0..DEPTH-1, so the midpoint
   // low + (high - low) / 2 is the floor of the mean
   assign nonempty = $signed({1'b0, low_ff}) <= high_ff;
   assign mid_sum  = {1'b0, low_ff} + {1'b0, high_ff[bsrch_pkg::LOW_WIDTH-1:0]};
   assign mid      = mid_sum[bsrch_pkg::INDEX_WIDTH:1];

   bsrch_ram #(
      .WIDTH (bsrch_pkg::ENTRY_WIDTH),
      .DEPTH (bsrch_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.write_en),
      .wr_addr (entry_index),
      .wr_data (entry_value),
      .rd_addr (mid),
      .rd_data (rd_data)
   );

   assign status.nonempty = nonempty;
   assign status.hit      = rd_data == key_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      low_in   = low_ff;
      high_in  = high_ff;
      key_in   = key_ff;
      found_in = found_ff;
      match_in = match_ff;
      if (cmd.load_req) begin
         low_in   = {1'b0, search_low};
         high_in  = {search_high[bsrch_pkg::SEARCH_HIGH_WIDTH-1], search_high};
         key_in   = search_key;
         found_in = 1'b0;
         match_in = '0;
      end else if (cmd.probe) begin
         if (status.hit) begin
            found_in = 1'b1;
            match_in = mid;
         end else if (rd_data < key_ff) begin
            low_in = {1'b0, mid} + bsrch_pkg::LOW_WIDTH'(1);
         end else begin
            high_in = $signed({2'b00, mid}) - bsrch_pkg::HIGH_WIDTH'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_ff;
         rsp_index_in = match_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= '0;
         high_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         low_ff       <= low_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff       <= key_in;
      found_ff     <= found_in;
      match_ff     <= match_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_index_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule

// ===== sv/sorted_table_binary_search.sv =====
`timescale 1ns / 1ps

// Binary search over a 256-entry table of signed 32-bit values that the
// user keeps in ascending order. A write request (tuser = 0) stores one
// entry and returns nothing. A search request (tuser = 1) carries an
// inclusive index range and a key; the block returns one response with a
// found flag in tuser and the matching index in tdata (0 when not found).
// An empty range (high below low) answers "not found" without a probe.
// Each probe reads the table through its registered read port: address
// in one cycle, compare in the next. A search over the whole table takes
// at most 9 probes. One search is in flight at a time; a finished
// response sits in an output register, so the next request is taken
// while it waits. Entries must be written before they are searched; the
// table has no reset.

`include "sorted_table_binary_search_macros.svh"

module sorted_table_binary_search (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // entry_index[7:0], entry_value[39:8], search_low[47:40],
   // search_high[56:48], search_key[88:57], zero pad[95:89]
   input  logic [95:0]  req_tdata,
   // opcode[0]
   input  logic         req_tuser,
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // match_index[7:0]
   output logic [7:0]   rsp_tdata,
   // found[0]
   output logic         rsp_tuser
);

   bsrch_pkg::cmd_type    cmd;
   bsrch_pkg::status_type status;

   // sequencer: idle / range check / probe / hand over response
   bsrch_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // bounds, key, table RAM and response register
   bsrch_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // a search in progress blocks further requests
   `BSRCH_ASSERT_NEXT(a_busy_after_search, clock, reset, cmd.load_req, !req_tready, "request taken during search")

   // a pending response is never overwritten
   `BSRCH_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.load_rsp, !rsp_tvalid || rsp_tready, "response overwritten")

   // table writes only on an accepted write request
   `BSRCH_ASSERT_NOW(a_write_on_accept, clock, reset, cmd.write_en, req_tvalid && req_tready && req_tuser == bsrch_pkg::OP_WRITE, "stray table write")

   // a miss reports index zero
   `BSRCH_ASSERT_NOW(a_miss_index_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == 8'd0, "miss with non-zero index")

endmodule
